>>> design/kped_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kped_pkg;

	localparam int TICK_W = 16;
	localparam int THR_W  = 10;
	localparam int KEY_W  = 4;
	localparam int CNT_W  = $clog2(TICK_W);
	localparam int CFG_IDX_W = 3;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// held key index, NO_KEY when nothing is held
	localparam logic [2:0] BTN_LEFT  = 3'd0;
	localparam logic [2:0] BTN_RIGHT = 3'd1;
	localparam logic [2:0] BTN_UP    = 3'd2;
	localparam logic [2:0] BTN_DOWN  = 3'd3;
	localparam logic [2:0] NO_KEY    = 3'd4;

	localparam logic [3:0] EV_UP        = 4'd0;
	localparam logic [3:0] EV_DOWN      = 4'd1;
	localparam logic [3:0] EV_BACK      = 4'd2;
	localparam logic [3:0] EV_SELECT    = 4'd3;
	localparam logic [3:0] EV_BACKLIGHT = 4'd4;
	localparam logic [3:0] EV_LOCK      = 4'd5;
	localparam logic [3:0] EV_RESET     = 4'd6;
	localparam logic [3:0] EV_POWER     = 4'd7;
	localparam logic [3:0] EV_PLAY      = 4'd8;
	localparam logic [3:0] EV_PULSE     = 4'd9;
	localparam logic [3:0] EV_NONE      = 4'd15;

	localparam logic [CFG_IDX_W-1:0] REG_MENU_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BL_NEVER_ON  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> design/key_press_event_decoder.sv
// Flow: an accepted tick is loaded, then passes ST_DIV, where a menu-mode up/down
//   hold runs the repeat test (16-step serial remainder unit), and then ST_FIN.
// The event is registered in ST_FIN once the output register is free; a new
//   tick is taken only in ST_IDLE, but while the previous event waits in the output register.
// Reset: asynchronous, active low; control and config registers return to defaults, no key held.
`timescale 1ns / 1ps
`default_nettype none

module key_press_event_decoder import kped_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [KEY_W-1:0]      keys_down,
	input  wire                  backlight_on,
	input  wire                  unit_off,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [3:0]           event_code,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [THR_W-1:0]      cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	kped_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	kped_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.keys_down    (keys_down),
		.backlight_on (backlight_on),
		.unit_off     (unit_off),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_code   (event_code)
	);

endmodule

`default_nettype wire

>>> design/kped_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kped_ctrl import kped_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				// skip the remainder pass when no repeat test applies
				if (!status.need_div) begin
					state_d = ST_FIN;
				end else begin
					cmd.div_step = 1'b1;
					if (status.div_last) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/kped_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module kped_dp import kped_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  wire [KEY_W-1:0]      keys_down,
	input  wire                  backlight_on,
	input  wire                  unit_off,
	input  wire                  cfg_valid,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [THR_W-1:0]      cfg_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [3:0]           event_code
);

	logic              menu_q;
	logic [THR_W-1:0]  long_q;
	logic [THR_W-1:0]  start_q;
	logic [THR_W-1:0]  per_q;
	logic              bl_never_q;

	logic [KEY_W-1:0]  prev_keys_q;
	logic [2:0]        held_key_q;
	logic [TICK_W-1:0] held_ticks_q;

	logic [3:0]        ev_base_q;
	logic              long_hit_q;
	logic [3:0]        long_ev_q;
	logic              need_div_q;
	logic [3:0]        rep_ev_q;
	logic              rep_fire_q;

	logic [TICK_W-1:0] div_d_q;
	logic [THR_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic [3:0]        event_q;

	// edge processing of one tick
	logic [2:0]        hk;
	logic [TICK_W-1:0] ht;
	logic [3:0]        ev;
	logic              both_lr;
	logic              wake;
	logic              long_hit;
	logic [3:0]        long_ev;
	logic              need_div;
	logic [TICK_W-1:0] start_ext;
	logic [TICK_W-1:0] long_ext;

	always_comb begin
		hk        = held_key_q;
		ht        = held_ticks_q;
		ev        = EV_NONE;
		both_lr   = keys_down[0] & keys_down[1];
		wake      = !bl_never_q && !backlight_on && !unit_off;
		start_ext = TICK_W'(start_q);
		long_ext  = TICK_W'(long_q);
		long_hit  = 1'b0;
		long_ev   = EV_NONE;
		need_div  = 1'b0;
		for (int i = 0; i < KEY_W; i++) begin
			if (!prev_keys_q[i] && keys_down[i]) begin
				if (wake) begin
					ev = EV_BACKLIGHT;
				end else begin
					if (menu_q && i >= 2) begin
						ev = (i == 2) ? EV_UP : EV_DOWN;
					end
					ht = '0;
					hk = 3'(i);
				end
			end
			if (prev_keys_q[i] && !keys_down[i] && hk == 3'(i)) begin
				if (ht < long_ext) begin
					if (i == 0) begin
						ev = EV_BACK;
					end else if (i == 1) begin
						ev = EV_SELECT;
					end else if (!menu_q) begin
						ev = (i == 2) ? EV_UP : EV_DOWN;
					end
				end
				hk = NO_KEY;
			end
		end
		if (hk != NO_KEY) begin
			if (ht != TICK_MAX) begin
				ht = ht + 1'b1;
			end
			if (ht == long_ext) begin
				if (both_lr) begin
					long_hit = 1'b1;
					long_ev  = EV_LOCK;
				end else if (!menu_q) begin
					long_hit = 1'b1;
					case (hk)
						BTN_UP:   long_ev = EV_PLAY;
						BTN_DOWN: long_ev = EV_PULSE;
						BTN_LEFT: long_ev = EV_RESET;
						default:  long_ev = EV_POWER;
					endcase
				end else if (hk == BTN_RIGHT) begin
					long_hit = 1'b1;
					long_ev  = EV_POWER;
				end
			end
			need_div = menu_q && ht >= start_ext && (hk == BTN_UP || hk == BTN_DOWN);
		end
	end

	// restoring remainder, one dividend bit per cycle
	logic [THR_W-1:0] per_eff;
	logic [THR_W:0]   rem_w;
	logic [THR_W:0]   rem_sub;
	logic [THR_W-1:0] rem_next;
	logic             div_last;

	assign per_eff  = (per_q == '0) ? THR_W'(1) : per_q;
	assign rem_w    = {rem_q, div_d_q[TICK_W-1]};
	assign rem_sub  = rem_w - {1'b0, per_eff};
	assign rem_next = (rem_w >= {1'b0, per_eff}) ? rem_sub[THR_W-1:0] : rem_w[THR_W-1:0];
	assign div_last = (cnt_q == CNT_W'(TICK_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q       <= 1'b0;
			long_q       <= THR_W'(50);
			start_q      <= THR_W'(25);
			per_q        <= THR_W'(2);
			bl_never_q   <= 1'b0;
			prev_keys_q  <= '0;
			held_key_q   <= NO_KEY;
			held_ticks_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_keys_q  <= keys_down;
				held_ticks_q <= ht;
			end
			// a mode write drops the held key
			if (cfg_valid && cfg_index == REG_MENU_MODE) begin
				held_key_q <= NO_KEY;
			end else if (cmd.load) begin
				held_key_q <= hk;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_MENU_MODE:    menu_q     <= cfg_data[0];
					REG_LONG_PRESS:   long_q     <= cfg_data;
					REG_REPEAT_START: start_q    <= cfg_data;
					REG_REPEAT_PER:   per_q      <= cfg_data;
					REG_BL_NEVER_ON:  bl_never_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.finish) begin
				out_valid_q <= (long_hit_q || (need_div_q && rep_fire_q) ||
				                ev_base_q != EV_NONE);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_base_q  <= ev;
			long_hit_q <= long_hit;
			long_ev_q  <= long_ev;
			need_div_q <= need_div;
			rep_ev_q   <= (hk == BTN_UP) ? EV_UP : EV_DOWN;
			rep_fire_q <= 1'b0;
			div_d_q    <= ht - start_ext;
			rem_q      <= '0;
			cnt_q      <= '0;
		end
		if (cmd.div_step) begin
			div_d_q <= {div_d_q[TICK_W-2:0], 1'b0};
			rem_q   <= rem_next;
			cnt_q   <= cnt_q + 1'b1;
			if (div_last) begin
				rep_fire_q <= (rem_next == '0);
			end
		end
		if (cmd.finish) begin
			if (long_hit_q) begin
				event_q <= long_ev_q;
			end else if (need_div_q && rep_fire_q) begin
				event_q <= rep_ev_q;
			end else begin
				event_q <= ev_base_q;
			end
		end
	end

	assign status.need_div = need_div_q;
	assign status.div_last = div_last;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign event_code      = event_q;

endmodule

`default_nettype wire
